### hw/rtl/cwsr_pkg.sv
// Package for the chunk window shift and remap block: request types, result kinds,
// sequencer states and default window parameters. No dependencies.
`default_nettype none
package cwsr_pkg;
	localparam int WindowXzDef = 4;
	localparam int WindowYDef = 2;
	localparam int RadiusDef = 1;
	localparam int ChunkShiftDef = 4;

	typedef enum logic [1:0] {
		FUNC_CAMERA = 2'd0,
		FUNC_READY = 2'd1,
		FUNC_INIT = 2'd2,
		FUNC_LOCATE = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		KIND_NO_SHIFT = 4'd0,
		KIND_MOVE = 4'd1,
		KIND_LOAD = 4'd2,
		KIND_EVICT = 4'd3,
		KIND_TAKEN = 4'd4,
		KIND_DROPPED = 4'd5,
		KIND_HIT = 4'd6,
		KIND_MISS = 4'd7,
		KIND_INIT = 4'd8
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_REMAP,
		ST_EVICT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [4:0] from_slot;
		logic [4:0] to_slot;
		logic signed [31:0] chunk_x;
		logic signed [31:0] chunk_y;
		logic signed [31:0] chunk_z;
		logic [3:0] local_x;
		logic [3:0] local_y;
		logic [3:0] local_z;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic in_x;
		logic in_y;
		logic in_z;
	} win_flags_t;
endpackage
`default_nettype wire

### hw/rtl/cwsr_window_test.sv
// Shared window test: relative offsets of one chunk against an origin and range checks.
// Depends on cwsr_pkg.
`default_nettype none
module cwsr_window_test import cwsr_pkg::*; #(
	parameter int WINDOW_XZ = WindowXzDef,
	parameter int WINDOW_Y = WindowYDef
) (
	input wire logic [31:0] cx,
	input wire logic [31:0] cy,
	input wire logic [31:0] cz,
	input wire logic [31:0] ox,
	input wire logic [31:0] oy,
	input wire logic [31:0] oz,
	output win_flags_t flags,
	output logic [31:0] rx,
	output logic [31:0] ry,
	output logic [31:0] rz
);
	always_comb begin
		rx = cx - ox;
		ry = cy - oy;
		rz = cz - oz;
		flags.in_x = rx < 32'(WINDOW_XZ);
		flags.in_y = ry < 32'(WINDOW_Y);
		flags.in_z = rz < 32'(WINDOW_XZ);
	end
endmodule
`default_nettype wire

### hw/rtl/chunk_window_shift_remap.sv
// Top level of the chunk window shift and remap block: sequencer, window state and
// result register. Depends on cwsr_pkg and cwsr_window_test.
//
// Channel | Direction | Payload    | Handshake
// req     | in        | in_item_t  | req_valid / req_ready
// res     | out       | out_item_t | res_valid / res_ready
//
// A ready, locate, init or unchanged camera request passes through the decode and output
// states after it is accepted; its result is registered in decode and marked valid in output.
// A window shift passes through decode, then walks every slot for remapping and every slot
// again for the eviction scan, each result waiting for the consumer.
// Reset restores the default origin with all slots occupied; no clearing pass is needed.
// A stalled result holds the sequencer, and no request is taken until all results leave.
`default_nettype none
module chunk_window_shift_remap import cwsr_pkg::*; #(
	parameter int WINDOW_XZ = WindowXzDef,
	parameter int WINDOW_Y = WindowYDef,
	parameter int RADIUS = RadiusDef,
	parameter int CHUNK_SHIFT = ChunkShiftDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire in_item_t req,
	output logic res_valid,
	input wire logic res_ready,
	output out_item_t res
);
	localparam int NSlot = WINDOW_XZ * WINDOW_Y * WINDOW_XZ;
	localparam int XW = $clog2(WINDOW_XZ);
	localparam int YW = (WINDOW_Y > 1) ? $clog2(WINDOW_Y) : 1;
	localparam int SW = $clog2(NSlot);

	state_t state_q, state_d;
	in_item_t req_q;
	logic [31:0] org_x_q, org_y_q, org_z_q;
	logic [31:0] old_x_q, old_y_q, old_z_q;
	logic [NSlot-1:0] occ_q, old_occ_q, reused_q;
	logic [XW-1:0] ix_q;
	logic [YW-1:0] iy_q;
	logic [XW-1:0] iz_q;
	logic [SW-1:0] idx_q;
	out_item_t res_q;
	logic res_valid_q;

	logic [31:0] fx, fy, fz;
	logic [31:0] tcx, tcy, tcz, tox, toy, toz, rx, ry, rz;
	win_flags_t flags;
	logic in_win;
	logic [SW-1:0] rel_slot, cur_slot;
	logic [31:0] nox, noy, noz;
	logic last_new, last_idx;
	logic out_free;
	logic keep_old, evict_now;
	logic [XW-1:0] step_x;
	logic [YW-1:0] step_y;
	logic [XW-1:0] step_z;
	out_item_t res_d;
	logic res_load;
	logic res_valid_d;

	function automatic logic [31:0] floor_chunk(input logic [31:0] v);
		return 32'($signed(v) >>> CHUNK_SHIFT);
	endfunction

	function automatic logic [3:0] local_bits(input logic [31:0] v);
		logic [31:0] m;
		m = v & ((32'd1 << CHUNK_SHIFT) - 32'd1);
		return m[3:0];
	endfunction

	always_comb begin
		fx = floor_chunk(req_q.pos_x);
		fy = floor_chunk(req_q.pos_y);
		fz = floor_chunk(req_q.pos_z);
		nox = fx - 32'(RADIUS);
		noy = fy - 32'(WINDOW_Y - 1);
		noz = fz - 32'(RADIUS);
		tox = org_x_q;
		toy = org_y_q;
		toz = org_z_q;
		tcx = fx;
		tcy = fy;
		tcz = fz;
		if (state_q == ST_REMAP) begin
			tcx = org_x_q + 32'(ix_q);
			tcy = org_y_q + 32'(iy_q);
			tcz = org_z_q + 32'(iz_q);
			tox = old_x_q;
			toy = old_y_q;
			toz = old_z_q;
		end else if (req_q.func == FUNC_READY) begin
			tcx = req_q.pos_x;
			tcy = req_q.pos_y;
			tcz = req_q.pos_z;
		end
	end

	cwsr_window_test #(.WINDOW_XZ(WINDOW_XZ), .WINDOW_Y(WINDOW_Y)) u_test (
		.cx(tcx), .cy(tcy), .cz(tcz), .ox(tox), .oy(toy), .oz(toz),
		.flags(flags), .rx(rx), .ry(ry), .rz(rz)
	);

	always_comb begin
		in_win = flags.in_x && flags.in_y && flags.in_z;
		rel_slot = SW'(32'(rx[XW-1:0]) + 32'(WINDOW_XZ) *
			(32'(ry[YW-1:0]) + 32'(WINDOW_Y) * 32'(rz[XW-1:0])));
		cur_slot = SW'(32'(ix_q) + 32'(WINDOW_XZ) *
			(32'(iy_q) + 32'(WINDOW_Y) * 32'(iz_q)));
		last_new = (32'(ix_q) == 32'(WINDOW_XZ - 1)) && (32'(iy_q) == 32'(WINDOW_Y - 1))
			&& (32'(iz_q) == 32'(WINDOW_XZ - 1));
		last_idx = 32'(idx_q) == 32'(NSlot - 1);
		out_free = !res_valid_q || res_ready;
		keep_old = in_win && old_occ_q[rel_slot];
		evict_now = old_occ_q[idx_q] && !reused_q[idx_q];
		step_x = ix_q + 1'b1;
		step_y = iy_q;
		step_z = iz_q;
		if (32'(ix_q) == 32'(WINDOW_XZ - 1)) begin
			step_x = '0;
			if (32'(iy_q) == 32'(WINDOW_Y - 1)) begin
				step_y = '0;
				step_z = (32'(iz_q) == 32'(WINDOW_XZ - 1)) ? '0 : iz_q + 1'b1;
			end else begin
				step_y = iy_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (req_valid && req_ready) state_d = ST_DECODE;
			ST_DECODE: begin
				if (req_q.func == FUNC_CAMERA && !(nox == org_x_q && noy == org_y_q
					&& noz == org_z_q))
					state_d = ST_REMAP;
				else
					state_d = ST_OUT;
			end
			ST_REMAP: if (out_free && last_new) state_d = ST_EVICT;
			ST_EVICT: begin
				if (last_idx && (out_free || !evict_now))
					state_d = ST_IDLE;
			end
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == ST_IDLE) && !res_valid_q;
	end

	always_comb begin
		res_valid_d = res_valid_q && !res_ready;
		case (state_q)
			ST_REMAP: if (out_free) res_valid_d = 1'b1;
			ST_EVICT: if (out_free && evict_now) res_valid_d = 1'b1;
			ST_OUT: if (out_free) res_valid_d = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		res_d = '0;
		res_load = 1'b0;
		case (state_q)
			ST_DECODE: begin
				res_load = 1'b1;
				res_d.last = 1'b1;
				res_d.chunk_x = fx;
				res_d.chunk_y = fy;
				res_d.chunk_z = fz;
				case (req_q.func)
					FUNC_READY: begin
						res_d.kind = in_win ? KIND_TAKEN : KIND_DROPPED;
						res_d.to_slot = in_win ? 5'(rel_slot) : 5'd0;
						res_d.chunk_x = req_q.pos_x;
						res_d.chunk_y = req_q.pos_y;
						res_d.chunk_z = req_q.pos_z;
					end
					FUNC_LOCATE: begin
						res_d.kind = (in_win && occ_q[rel_slot]) ? KIND_HIT : KIND_MISS;
						res_d.to_slot = (in_win && occ_q[rel_slot]) ? 5'(rel_slot) : 5'd0;
						res_d.local_x = local_bits(req_q.pos_x);
						res_d.local_y = local_bits(req_q.pos_y);
						res_d.local_z = local_bits(req_q.pos_z);
					end
					FUNC_INIT: res_d.kind = KIND_INIT;
					default: res_d.kind = KIND_NO_SHIFT;
				endcase
			end
			ST_REMAP: if (out_free) begin
				res_load = 1'b1;
				res_d.to_slot = 5'(cur_slot);
				res_d.chunk_x = tcx;
				res_d.chunk_y = tcy;
				res_d.chunk_z = tcz;
				if (keep_old) begin
					res_d.kind = KIND_MOVE;
					res_d.from_slot = 5'(rel_slot);
				end else begin
					res_d.kind = KIND_LOAD;
				end
				res_d.last = last_new && ((old_occ_q & ~(reused_q |
					(keep_old ? (NSlot'(1) << rel_slot) : '0))) == '0);
			end
			ST_EVICT: if (out_free && evict_now) begin
				res_load = 1'b1;
				res_d.kind = KIND_EVICT;
				res_d.from_slot = 5'(idx_q);
				res_d.chunk_x = old_x_q + 32'(ix_q);
				res_d.chunk_y = old_y_q + 32'(iy_q);
				res_d.chunk_z = old_z_q + 32'(iz_q);
				res_d.last = ((old_occ_q & ~reused_q) >> idx_q) == NSlot'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			org_x_q <= -32'(RADIUS);
			org_y_q <= -32'(WINDOW_Y - 1);
			org_z_q <= -32'(RADIUS);
			occ_q <= '1;
			reused_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_valid_q <= res_valid_d;
			case (state_q)
				ST_DECODE: begin
					if (req_q.func == FUNC_INIT) begin
						org_x_q <= nox;
						org_y_q <= noy;
						org_z_q <= noz;
						occ_q <= '1;
						reused_q <= '0;
					end else if (req_q.func == FUNC_CAMERA) begin
						org_x_q <= nox;
						org_y_q <= noy;
						org_z_q <= noz;
						if (state_d == ST_REMAP) reused_q <= '0;
					end else if (req_q.func == FUNC_READY && in_win) begin
						occ_q[rel_slot] <= 1'b1;
					end
				end
				ST_REMAP: if (out_free) begin
					if (keep_old) begin
						occ_q[cur_slot] <= 1'b1;
						reused_q[rel_slot] <= 1'b1;
					end else begin
						occ_q[cur_slot] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) req_q <= req;
		if (res_load) res_q <= res_d;
		case (state_q)
			ST_DECODE: begin
				old_x_q <= org_x_q;
				old_y_q <= org_y_q;
				old_z_q <= org_z_q;
				old_occ_q <= occ_q;
				ix_q <= '0;
				iy_q <= '0;
				iz_q <= '0;
				idx_q <= '0;
			end
			ST_REMAP: if (out_free) begin
				ix_q <= step_x;
				iy_q <= step_y;
				iz_q <= step_z;
			end
			ST_EVICT: if (!last_idx && (out_free || !evict_now)) begin
				idx_q <= idx_q + 1'b1;
				ix_q <= step_x;
				iy_q <= step_y;
				iz_q <= step_z;
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

`ifndef NO_ASSERTIONS
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req_ready) else $error("request taken while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> $stable(res)) else $error("result changed in stall");
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && state_q == ST_IDLE) |-> res.last)
		else $error("final result without last");
`endif
endmodule
`default_nettype wire

### dv/chunk_window_shift_remap_tb.sv
// Self-checking testbench for the chunk window shift and remap block: camera,
// ready, init and locate requests are predicted and checked result by result.
// Depends on cwsr_pkg and the chunk_window_shift_remap RTL.
`default_nettype none
module chunk_window_shift_remap_tb;
	import cwsr_pkg::*;

	localparam int WXZ = WindowXzDef;
	localparam int WY = WindowYDef;
	localparam int RAD = RadiusDef;
	localparam int CSH = ChunkShiftDef;
	localparam int NSLOT = WXZ * WY * WXZ;
	localparam int NRAND = 391;
	localparam int LIMIT = 8000000;

	class window_scoreboard;
		logic [31:0] org_x, org_y, org_z;
		bit occ[NSLOT];
		out_item_t pending[$];
		int errors;
		int checked;

		function new();
			org_x = -RAD;
			org_y = -(WY - 1);
			org_z = -RAD;
			foreach (occ[i]) occ[i] = 1'b1;
			errors = 0;
			checked = 0;
		endfunction

		function logic [31:0] floor_div(logic [31:0] v);
			return $unsigned($signed(v) >>> CSH);
		endfunction

		function void push(kind_t k, int fs, int ts, logic [31:0] cx, logic [31:0] cy,
				logic [31:0] cz, logic [3:0] lx, logic [3:0] ly, logic [3:0] lz);
			out_item_t r;
			r.kind = k;
			r.from_slot = 5'(fs);
			r.to_slot = 5'(ts);
			r.chunk_x = cx;
			r.chunk_y = cy;
			r.chunk_z = cz;
			r.local_x = lx;
			r.local_y = ly;
			r.local_z = lz;
			r.last = 1'b0;
			pending = {pending, r};
		endfunction

		function bit window_slot(logic [31:0] x, logic [31:0] y, logic [31:0] z,
				output int s);
			logic [31:0] rx, ry, rz;
			rx = x - org_x;
			ry = y - org_y;
			rz = z - org_z;
			s = 0;
			if (rx >= WXZ || ry >= WY || rz >= WXZ) return 1'b0;
			s = int'(rx + WXZ * (ry + WY * rz));
			return 1'b1;
		endfunction

		function void note_request(in_item_t q);
			logic [31:0] cx, cy, cz, ox, oy, oz, wx, wy, wz, rx, ry, rz;
			logic [3:0] lx, ly, lz;
			bit old_occ[NSLOT];
			bit reused[NSLOT];
			int s, os, ns;
			cx = floor_div(q.pos_x);
			cy = floor_div(q.pos_y);
			cz = floor_div(q.pos_z);
			lx = 4'(q.pos_x & ((32'd1 << CSH) - 32'd1));
			ly = 4'(q.pos_y & ((32'd1 << CSH) - 32'd1));
			lz = 4'(q.pos_z & ((32'd1 << CSH) - 32'd1));
			case (func_t'(q.func))
				FUNC_READY: begin
					if (window_slot(q.pos_x, q.pos_y, q.pos_z, s)) begin
						occ[s] = 1'b1;
						push(KIND_TAKEN, 0, s, q.pos_x, q.pos_y, q.pos_z, 0, 0, 0);
					end else begin
						push(KIND_DROPPED, 0, 0, q.pos_x, q.pos_y, q.pos_z, 0, 0, 0);
					end
				end
				FUNC_LOCATE: begin
					if (window_slot(cx, cy, cz, s) && occ[s])
						push(KIND_HIT, 0, s, cx, cy, cz, lx, ly, lz);
					else
						push(KIND_MISS, 0, 0, cx, cy, cz, lx, ly, lz);
				end
				FUNC_INIT: begin
					org_x = cx - RAD;
					org_y = cy - (WY - 1);
					org_z = cz - RAD;
					foreach (occ[i]) occ[i] = 1'b1;
					push(KIND_INIT, 0, 0, cx, cy, cz, 0, 0, 0);
				end
				default: begin
					ox = org_x;
					oy = org_y;
					oz = org_z;
					org_x = cx - RAD;
					org_y = cy - (WY - 1);
					org_z = cz - RAD;
					if (org_x == ox && org_y == oy && org_z == oz) begin
						push(KIND_NO_SHIFT, 0, 0, cx, cy, cz, 0, 0, 0);
					end else begin
						old_occ = occ;
						foreach (reused[i]) reused[i] = 1'b0;
						for (int z = 0; z < WXZ; z++)
							for (int y = 0; y < WY; y++)
								for (int x = 0; x < WXZ; x++) begin
									wx = org_x + x;
									wy = org_y + y;
									wz = org_z + z;
									ns = x + WXZ * (y + WY * z);
									rx = wx - ox;
									ry = wy - oy;
									rz = wz - oz;
									os = rx + WXZ * (ry + WY * rz);
									if (rx < WXZ && ry < WY && rz < WXZ && old_occ[os]) begin
										occ[ns] = 1'b1;
										reused[os] = 1'b1;
										push(KIND_MOVE, os, ns, wx, wy, wz, 0, 0, 0);
									end else begin
										occ[ns] = 1'b0;
										push(KIND_LOAD, 0, ns, wx, wy, wz, 0, 0, 0);
									end
								end
						for (int i = 0; i < NSLOT; i++)
							if (old_occ[i] && !reused[i])
								push(KIND_EVICT, i, 0, ox + i % WXZ, oy + (i / WXZ) % WY,
									oz + i / (WXZ * WY), 0, 0, 0);
					end
				end
			endcase
			pending[pending.size() - 1].last = 1'b1;
		endfunction

		function void check_result(out_item_t got, longint t);
			out_item_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", t, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got !== e) begin
				$display("%0t: mismatch expected %p actual %p", t, e, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	in_item_t req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	out_item_t res;

	window_scoreboard sb;
	int cycles = 0;
	bit sending_done = 1'b0;
	bit hold_off = 1'b0;
	int camera_moves = 0;

	chunk_window_shift_remap dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(func_t f, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int g;
		in_item_t q;
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		q.func = f;
		q.pos_x = x;
		q.pos_y = y;
		q.pos_z = z;
		req_valid <= 1'b1;
		req <= q;
		do @(posedge clk); while (!req_ready);
		sb.note_request(req);
		if (f == FUNC_CAMERA) camera_moves++;
	endtask

	// Voxel coordinate in a chunk within spread of a centre chunk, at a random place inside it.
	function logic [31:0] near(logic [31:0] c, int spread);
		return ((c + $urandom_range(0, 2 * spread) - spread) << CSH) | $urandom_range(0, 15);
	endfunction

	function logic [31:0] rand_word();
		return $urandom();
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("chunk_window_shift_remap_tb: done, errors");
			$finish;
		end
	end

	initial begin : receiver
		int g;
		wait (arst_n);
		forever begin
			if (hold_off) begin
				res_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			g = gap_len();
			if (g > 0) begin
				res_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			res_ready <= 1'b1;
			@(posedge clk);
			if (res_valid && res_ready) sb.check_result(res, $time);
		end
	end

	initial begin : stimulus
		logic [31:0] cx, cy, cz;
		func_t f;
		int r;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_request(FUNC_LOCATE, 0, 0, 0);
		send_request(FUNC_LOCATE, 32'h7fffffff, 32'h80000000, 32'hffffffff);
		send_request(FUNC_READY, 0, 0, 0);
		send_request(FUNC_READY, 32'h80000000, 32'h7fffffff, 0);
		send_request(FUNC_CAMERA, 5, 3, 7);
		send_request(FUNC_CAMERA, 16, 0, 0);
		send_request(FUNC_CAMERA, 16, 16, 0);
		send_request(FUNC_LOCATE, 20, 0, 3);
		send_request(FUNC_CAMERA, 32'hffffff00, 32'h00000100, 32'h00001000);
		send_request(FUNC_READY, 32'hfffffff0, 16, 256);
		send_request(FUNC_LOCATE, 32'hffffff05, 32'h0000010f, 32'h0000100a);
		send_request(FUNC_INIT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_request(FUNC_CAMERA, 32'h80000000, 32'h80000000, 32'h80000000);
		send_request(FUNC_LOCATE, 32'h80000000, 32'h80000000, 32'h80000000);
		send_request(FUNC_INIT, 32'h80000000, 32'h80000000, 32'h80000000);
		send_request(FUNC_CAMERA, 32'h7ffffff0, 32'h7ffffff0, 32'h7ffffff0);
		send_request(FUNC_INIT, 0, 0, 0);
		send_request(FUNC_CAMERA, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		send_request(FUNC_READY, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		hold_off = 1'b1;
		cx = 0;
		cy = 0;
		cz = 0;
		for (int i = 0; i < NRAND; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				cx = rand_word();
				cy = rand_word();
				cz = rand_word();
				send_request(FUNC_INIT, near(cx, 0), near(cy, 0), near(cz, 0));
			end else if (r < 22) begin
				cx = cx + $urandom_range(0, 2) - 1;
				cy = cy + $urandom_range(0, 2) - 1;
				cz = cz + $urandom_range(0, 2) - 1;
				send_request(FUNC_CAMERA, near(cx, 0), near(cy, 0), near(cz, 0));
			end else if (r < 50) begin
				send_request(FUNC_READY, cx + $urandom_range(0, 5) - 3,
					cy + $urandom_range(0, 3) - 2, cz + $urandom_range(0, 5) - 3);
			end else if (r < 88) begin
				send_request(FUNC_LOCATE, near(cx, 3), near(cy, 2), near(cz, 3));
			end else begin
				f = func_t'($urandom_range(0, 3));
				send_request(f, rand_word(), rand_word(), rand_word());
				if (f == FUNC_CAMERA || f == FUNC_INIT) begin
					cx = sb.org_x + RAD;
					cy = sb.org_y + WY - 1;
					cz = sb.org_z + RAD;
				end
			end
		end
		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Checked %0d results over %0d requests, %0d camera updates among them.",
			sb.checked, NRAND + 19, camera_moves);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("chunk_window_shift_remap_tb: done, clean");
		else
			$display("chunk_window_shift_remap_tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
